@@ rtl/pgfs_pkg.sv @@
// ---------------------------------------------------------------------------
// pgfs_pkg
// types and constants shared by the pairwise gravity force sum block
// ---------------------------------------------------------------------------
`default_nettype none

package pgfs_pkg;

   localparam int POS_W     = 24;
   localparam int MASS_W    = 16;
   localparam int SCALE_W   = 32;
   localparam int FORCE_W   = 48;
   localparam int IDX_W     = 6;
   localparam int DIFF_W    = POS_W + 1;
   localparam int MAG_W     = POS_W;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int DEN_W     = SQ_W + 2;
   localparam int MM_W      = 2 * MASS_W;
   localparam int A_W       = SCALE_W + MM_W;
   localparam int PP_W      = 32 + MAG_W;
   localparam int NUM_W     = A_W + MAG_W + 2;
   localparam int ACC_W     = 56;
   localparam int DIV_STEPS = FORCE_W;
   localparam int STEP_W    = 6;

   localparam logic [2:0]  CSR_ADDR_W_BITS  = 3'd3;
   localparam logic        CSR_IDX_FORCE_SCALE = 1'b0;
   localparam logic [SCALE_W-1:0] FORCE_SCALE_RESET = 32'h0100_0000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [MASS_W-1:0]       body_mass;
      logic                    affected;
   } body_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_JSEL,
      ST_READ,
      ST_DIFF,
      ST_SQR,
      ST_SUM,
      ST_CHECK,
      ST_DIV_INIT,
      ST_DIV,
      ST_ACC,
      ST_EMIT
   } pgfs_state_type;

   typedef struct packed {
      logic load;
      logic acc_clear;
      logic coin_set;
      logic div_init;
      logic div_step;
      logic acc_add;
      logic emit;
      logic last;
   } pgfs_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic affected;
      logic out_free;
   } pgfs_status_type;

endpackage

`default_nettype wire

@@ rtl/pgfs_if.sv @@
// ---------------------------------------------------------------------------
// pgfs_if
// request and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface pgfs_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic [15:0]        body_mass;
   logic               affected;
   logic               last_body;

   modport source (output valid, pos_x, pos_y, pos_z, body_mass, affected, last_body,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, body_mass, affected, last_body,
                 output ready);
endinterface

interface pgfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] force_x;
   logic signed [47:0] force_y;
   logic signed [47:0] force_z;
   logic [5:0]         body_index;
   logic               saturated;
   logic               coincident;
   logic               last_result;

   modport source (output valid, force_x, force_y, force_z, body_index, saturated,
                   coincident, last_result, input ready);
   modport sink (input valid, force_x, force_y, force_z, body_index, saturated,
                 coincident, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/pairwise_gravity_force_sum.sv @@
// ---------------------------------------------------------------------------
// pairwise_gravity_force_sum
// net gravity force per body over all body pairs of a frame
//
// Requests load one body each (position, mass, affected flag) and are taken
// one per cycle while the block is loading. A request with last_body set
// closes the frame; further requests are held off until the last result of
// the frame has entered the output register. One result per loaded body then
// follows, in load order. For each body i every other body j goes through
// select, read, difference, squares, distance and check; a pair that is not
// coincident and whose body i is affected then takes division init, the
// 48-step restoring dividers that run the three components side by side and
// accumulation. Each result adds passing over body i, closing the scan and
// the emit. The result sits in an output register: while it waits the
// sequencer goes on with the next body and stops at its emit. Bodies past
// MAX_BODIES are dropped. Reset returns the sequencer to loading with an
// empty frame and force_scale at 1.0; the body store needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module pairwise_gravity_force_sum
   import pgfs_pkg::*;
#(
   parameter int  MAX_BODIES = 64,
   localparam int ADDR_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   pgfs_req_if.sink                          req,
   pgfs_rsp_if.source                        rsp,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W_BITS-1:0]   csr_paddr,
   input  wire logic [SCALE_W-1:0]           csr_pwdata,
   output logic [SCALE_W-1:0]                csr_prdata,
   output logic                              csr_pready
);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   pgfs_cmd_type       cmd;
   pgfs_status_type    status;
   body_type           wr_body;
   logic [ADDR_W-1:0]  wr_addr, rd_addr_i, rd_addr_j;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign scale_in   = (csr_wr && csr_paddr[2] == CSR_IDX_FORCE_SCALE) ? csr_pwdata
                                                                        : scale_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FORCE_SCALE) ? scale_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) scale_ff <= FORCE_SCALE_RESET;
      else scale_ff <= scale_in;
   end

   assign wr_body = '{pos_x: req.pos_x, pos_y: req.pos_y, pos_z: req.pos_z,
                      body_mass: req.body_mass, affected: req.affected};

   pgfs_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_last_body (req.last_body),
      .req_ready     (req.ready),
      .status        (status),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr_i     (rd_addr_i),
      .rd_addr_j     (rd_addr_j)
   );

   pgfs_datapath #(.MAX_BODIES(MAX_BODIES)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .wr_body     (wr_body),
      .wr_addr     (wr_addr),
      .rd_addr_i   (rd_addr_i),
      .rd_addr_j   (rd_addr_j),
      .force_scale (scale_ff),
      .rsp         (rsp)
   );

   a_no_load_in_pair: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !(cmd.div_step || cmd.div_init || cmd.acc_add))
      else $error("request taken during pair phase");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwritten before handover");

   a_last_reloads: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> req.ready)
      else $error("not loading after final result");

endmodule

`default_nettype wire

@@ rtl/pgfs_ctrl.sv @@
// ---------------------------------------------------------------------------
// pgfs_ctrl
// sequencer for body loading, pair loop, division steps and result emit
// ---------------------------------------------------------------------------
`default_nettype none

module pgfs_ctrl
   import pgfs_pkg::*;
#(
   parameter int  MAX_BODIES = 64,
   localparam int ADDR_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1,
   localparam int CNT_W  = $clog2(MAX_BODIES + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last_body,
   output logic                 req_ready,
   input  wire pgfs_status_type status,
   output pgfs_cmd_type         cmd,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [ADDR_W-1:0]    rd_addr_i,
   output logic [ADDR_W-1:0]    rd_addr_j
);

   pgfs_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;
   logic              room;
   logic              last_i;
   logic              skip_pair;
   logic [CNT_W-1:0]  count_inc;

   assign accept    = req_valid && (state_ff == ST_LOAD);
   assign room      = count_ff < CNT_W'(MAX_BODIES);
   assign count_inc = room ? count_ff + 1'b1 : count_ff;
   assign last_i    = (i_ff == n_ff - 1'b1);
   assign skip_pair = status.den_zero || !status.affected;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         n_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_body) state_in = ST_JSEL;
         end
         ST_JSEL: begin
            if (j_ff == n_ff) state_in = ST_EMIT;
            else if (j_ff != i_ff) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_SQR;
         ST_SQR:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = skip_pair ? ST_JSEL : ST_DIV_INIT;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_ACC;
         end
         ST_ACC: state_in = ST_JSEL;
         ST_EMIT: begin
            if (status.out_free) state_in = last_i ? ST_LOAD : ST_JSEL;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      cmd.last      = last_i;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready     = 1'b1;
            cmd.load      = accept && room;
            cmd.acc_clear = accept && req_last_body;
         end
         ST_CHECK:    cmd.coin_set = status.den_zero;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_ACC:      cmd.acc_add  = 1'b1;
         ST_EMIT: begin
            cmd.emit      = status.out_free;
            cmd.acc_clear = status.out_free;
         end
         default: begin
         end
      endcase
   end

   // counters
   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = count_inc;
               if (req_last_body) begin
                  n_in = count_inc;
                  i_in = '0;
                  j_in = '0;
               end
            end
         end
         ST_JSEL: begin
            if (j_ff != n_ff && j_ff == i_ff) j_in = j_ff + 1'b1;
         end
         ST_CHECK: begin
            if (skip_pair) j_in = j_ff + 1'b1;
         end
         ST_DIV_INIT: step_in = '0;
         ST_DIV:      step_in = step_ff + 1'b1;
         ST_ACC:      j_in = j_ff + 1'b1;
         ST_EMIT: begin
            if (status.out_free) begin
               if (last_i) begin
                  count_in = '0;
               end else begin
                  i_in = i_ff + 1'b1;
                  j_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_addr   = count_ff[ADDR_W-1:0];
   assign rd_addr_i = i_ff[ADDR_W-1:0];
   assign rd_addr_j = j_ff[ADDR_W-1:0];

endmodule

`default_nettype wire

@@ rtl/pgfs_datapath.sv @@
// ---------------------------------------------------------------------------
// pgfs_datapath
// body store, pair arithmetic, per-component dividers, accumulators, output
// ---------------------------------------------------------------------------
`default_nettype none

module pgfs_datapath
   import pgfs_pkg::*;
#(
   parameter int  MAX_BODIES = 64,
   localparam int ADDR_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pgfs_cmd_type       cmd,
   output pgfs_status_type         status,
   input  wire body_type           wr_body,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [ADDR_W-1:0]  rd_addr_i,
   input  wire logic [ADDR_W-1:0]  rd_addr_j,
   input  wire logic [SCALE_W-1:0] force_scale,
   pgfs_rsp_if.source              rsp
);

   localparam logic [ACC_W-1:0] CLIP_VAL = ACC_W'(64'h1_0000_0000_0000);
   localparam logic signed [ACC_W-1:0] ACC_POS = ACC_W'(64'sh7FFF_FFFF_FFFF);
   localparam logic signed [ACC_W-1:0] ACC_NEG = -ACC_W'(64'sh8000_0000_0000);

   body_type body_mem [MAX_BODIES];
   body_type rd_i_ff, rd_j_ff;

   logic signed [DIFF_W-1:0] d_ff [3], d_in [3];
   logic [MM_W-1:0]          mm_ff, mm_in;
   logic                     aff_ff, aff_in;
   logic [MAG_W-1:0]         mag_ff [3], mag_in [3];
   logic                     neg_ff [3], neg_in [3];
   logic [SQ_W-1:0]          sq_ff [3], sq_in [3];
   logic [A_W-1:0]           a_ff, a_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [PP_W-1:0]          plo_ff [3], plo_in [3];
   logic [PP_W-1:0]          phi_ff [3], phi_in [3];
   logic [NUM_W-1:0]         num_ff [3], num_in [3];
   logic [DEN_W-1:0]         rem_ff [3], rem_in [3];
   logic [FORCE_W-1:0]       low_ff [3], low_in [3];
   logic [FORCE_W-1:0]       q_ff [3], q_in [3];
   logic                     clip_ff [3], clip_in [3];
   logic signed [ACC_W-1:0]  acc_ff [3], acc_in [3];
   logic                     sat_ff, sat_in;
   logic                     coin_ff, coin_in;

   logic signed [FORCE_W-1:0] fx_ff, fy_ff, fz_ff;
   logic signed [FORCE_W-1:0] fout [3];
   logic [IDX_W-1:0]          idx_ff;
   logic                      osat_ff, coin_out_ff, last_ff;
   logic                      valid_ff, valid_in;
   logic                      clamp_any;

   always_ff @(posedge clock) begin
      if (cmd.load) body_mem[wr_addr] <= wr_body;
      rd_i_ff <= body_mem[rd_addr_i];
      rd_j_ff <= body_mem[rd_addr_j];
   end

   // pair pipeline
   always_comb begin
      logic signed [POS_W-1:0] pi [3];
      logic signed [POS_W-1:0] pj [3];
      logic [PP_W+32-1:0]      wide;
      pi = '{rd_i_ff.pos_x, rd_i_ff.pos_y, rd_i_ff.pos_z};
      pj = '{rd_j_ff.pos_x, rd_j_ff.pos_y, rd_j_ff.pos_z};
      mm_in  = MM_W'(rd_i_ff.body_mass) * MM_W'(rd_j_ff.body_mass);
      aff_in = rd_i_ff.affected;
      a_in   = A_W'(force_scale) * A_W'(mm_ff);
      den_in = DEN_W'(sq_ff[0]) + DEN_W'(sq_ff[1]) + DEN_W'(sq_ff[2]);
      for (int k = 0; k < 3; k++) begin
         d_in[k]   = DIFF_W'(pj[k]) - DIFF_W'(pi[k]);
         neg_in[k] = d_ff[k][DIFF_W-1];
         mag_in[k] = MAG_W'(d_ff[k][DIFF_W-1] ? -d_ff[k] : d_ff[k]);
         sq_in[k]  = SQ_W'(mag_in[k]) * SQ_W'(mag_in[k]);
         plo_in[k] = PP_W'(a_ff[31:0]) * PP_W'(mag_ff[k]);
         phi_in[k] = PP_W'(a_ff[A_W-1:32]) * PP_W'(mag_ff[k]);
         wide      = {phi_ff[k], 32'b0} + (PP_W+32)'(plo_ff[k]);
         num_in[k] = {wide, 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      mm_ff  <= mm_in;
      aff_ff <= aff_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      sq_ff  <= sq_in;
      a_ff   <= a_in;
      den_ff <= den_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      num_ff <= num_in;
   end

   // restoring dividers, one quotient bit per step
   always_comb begin
      logic [DEN_W:0] r2;
      for (int k = 0; k < 3; k++) begin
         rem_in[k]  = rem_ff[k];
         low_in[k]  = low_ff[k];
         q_in[k]    = q_ff[k];
         clip_in[k] = clip_ff[k];
         r2 = {rem_ff[k], low_ff[k][FORCE_W-1]};
         if (cmd.div_init) begin
            clip_in[k] = (DEN_W+FORCE_W)'(num_ff[k]) >= {den_ff, {FORCE_W{1'b0}}};
            rem_in[k]  = DEN_W'(num_ff[k][NUM_W-1:FORCE_W]);
            low_in[k]  = num_ff[k][FORCE_W-1:0];
            q_in[k]    = '0;
         end else if (cmd.div_step) begin
            low_in[k] = {low_ff[k][FORCE_W-2:0], 1'b0};
            if (r2 >= {1'b0, den_ff}) begin
               rem_in[k] = DEN_W'(r2 - {1'b0, den_ff});
               q_in[k]   = {q_ff[k][FORCE_W-2:0], 1'b1};
            end else begin
               rem_in[k] = r2[DEN_W-1:0];
               q_in[k]   = {q_ff[k][FORCE_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      clip_ff <= clip_in;
   end

   // accumulation and flags
   always_comb begin
      logic [ACC_W-1:0] c;
      sat_in  = sat_ff;
      coin_in = coin_ff;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = acc_ff[k];
         c = clip_ff[k] ? CLIP_VAL : ACC_W'(q_ff[k]);
         if (cmd.acc_clear) acc_in[k] = '0;
         else if (cmd.acc_add) acc_in[k] = neg_ff[k] ? acc_ff[k] - $signed(c)
                                                    : acc_ff[k] + $signed(c);
      end
      if (cmd.acc_clear) begin
         sat_in  = 1'b0;
         coin_in = 1'b0;
      end else begin
         if (cmd.acc_add) sat_in = sat_ff | clip_ff[0] | clip_ff[1] | clip_ff[2];
         if (cmd.coin_set) coin_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         sat_ff  <= 1'b0;
         coin_ff <= 1'b0;
      end else begin
         sat_ff  <= sat_in;
         coin_ff <= coin_in;
      end
   end

   // output clamp and register
   always_comb begin
      clamp_any = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (acc_ff[k] > ACC_POS) begin
            fout[k]   = ACC_POS[FORCE_W-1:0];
            clamp_any = 1'b1;
         end else if (acc_ff[k] < ACC_NEG) begin
            fout[k]   = ACC_NEG[FORCE_W-1:0];
            clamp_any = 1'b1;
         end else begin
            fout[k] = acc_ff[k][FORCE_W-1:0];
         end
      end
   end

   assign valid_in = cmd.emit ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (cmd.emit) begin
         fx_ff       <= fout[0];
         fy_ff       <= fout[1];
         fz_ff       <= fout[2];
         idx_ff      <= IDX_W'(rd_addr_i);
         osat_ff     <= sat_ff | clamp_any;
         coin_out_ff <= coin_ff;
         last_ff     <= cmd.last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.force_x     = fx_ff;
   assign rsp.force_y     = fy_ff;
   assign rsp.force_z     = fz_ff;
   assign rsp.body_index  = idx_ff;
   assign rsp.saturated   = osat_ff;
   assign rsp.coincident  = coin_out_ff;
   assign rsp.last_result = last_ff;

   assign status.den_zero = (den_ff == '0);
   assign status.affected = aff_ff;
   assign status.out_free = !valid_ff || rsp.ready;

endmodule

`default_nettype wire
